FILE: hw/rtl/cpp_pkg.sv
// Shared types and constants for the camera point projection block.
// Depends on nothing; imported by the top level.
package cpp_pkg;

   // Coordinate width of the point and pixel fields (signed Q.8)
   localparam int CoordW = 24;

   // Register widths
   localparam int RotW     = 48;
   localparam int TransW   = 63;
   localparam int FocalW   = 20;
   localparam int KappaW   = 32;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 63;

   // Register indexes
   localparam logic [CsrIdxW-1:0] REG_ROT_ROW0    = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_ROT_ROW1    = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_ROT_ROW2    = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_TRANSLATION = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_FOCAL       = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_KAPPA       = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_TELECENTRIC = 3'd6;

   // Reset values: identity rotation, focal length 50.0
   localparam logic [RotW-1:0]   RotRow0Rst = 48'h0000_0000_4000;
   localparam logic [RotW-1:0]   RotRow1Rst = 48'h0000_4000_0000;
   localparam logic [RotW-1:0]   RotRow2Rst = 48'h4000_0000_0000;
   localparam logic [FocalW-1:0] FocalRst   = 20'd12800;

   typedef struct packed {
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
      logic signed [CoordW-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] pixel_row;
      logic signed [CoordW-1:0] pixel_col;
      logic                     valid_res;
      logic                     saturated;
   } rsp_type;

endpackage

FILE: hw/rtl/camera_point_projection.sv
// Camera point projection top level: rigid transform, projection, radial distortion.
// Depends on cpp_pkg, cpp_delay, cpp_div_pipe and cpp_sqrt_pipe.
//
//   port group   direction  payload     handshake
//   req_*        in         req_type    req_valid / req_stall
//   rsp_*        out        rsp_type    rsp_valid / rsp_stall
//   csr_*        in         63-bit data csr_write, csr_index
//
// One request enters per cycle while no stalled result is held at the output. The path
// runs through the 32-stage projection dividers, the 33-stage square root and the
// 33-stage distortion dividers, one bit per stage after each input register.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module camera_point_projection
   import cpp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   localparam int ProdW = CoordW + 16;
   localparam int AccW  = CoordW + 20;
   localparam int CamW  = AccW - 14;
   localparam int FpW   = CamW + 21;
   localparam int N1W   = FpW + 2;
   localparam int D1W   = CamW;
   localparam int Q1W   = 31;
   localparam int N2W   = 48;
   localparam int D2W   = 34;
   localparam int Q2W   = 32;
   localparam int SqW   = 64;

   localparam logic signed [63:0] PreLim = 64'sd1073741824;
   localparam logic [62:0]        OneQ30 = 63'd1 << 30;
   localparam logic [62:0]        ArgCap = 63'd1 << 62;
   localparam logic [32:0]        OutMag = 33'd1 << (CoordW - 1);
   localparam logic [32:0]        OutMax = OutMag - 33'd1;

   typedef struct packed {
      logic                   bad;
      logic [1:0]             neg;
      logic signed [CamW-1:0] cam0;
      logic signed [CamW-1:0] cam1;
   } side1_type;

   typedef struct packed {
      logic               ok;
      logic               sat;
      logic signed [31:0] u0;
      logic signed [31:0] u1;
   } car_type;

   typedef struct packed {
      logic       ok;
      logic       sat;
      logic [1:0] neg;
   } side3_type;

   // ---------------- configuration registers ----------------
   logic [RotW-1:0]   rot_ff [0:2];
   logic [TransW-1:0] trans_ff;
   logic [FocalW-1:0] focal_ff;
   logic [KappaW-1:0] kappa_ff;
   logic              tele_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= RotRow0Rst;
         rot_ff[1] <= RotRow1Rst;
         rot_ff[2] <= RotRow2Rst;
         trans_ff  <= '0;
         focal_ff  <= FocalRst;
         kappa_ff  <= '0;
         tele_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_ROT_ROW0:    rot_ff[0] <= csr_wdata[RotW-1:0];
            REG_ROT_ROW1:    rot_ff[1] <= csr_wdata[RotW-1:0];
            REG_ROT_ROW2:    rot_ff[2] <= csr_wdata[RotW-1:0];
            REG_TRANSLATION: trans_ff  <= csr_wdata[TransW-1:0];
            REG_FOCAL:       focal_ff  <= csr_wdata[FocalW-1:0];
            REG_KAPPA:       kappa_ff  <= csr_wdata[KappaW-1:0];
            REG_TELECENTRIC: tele_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline advance ----------------
   logic    en;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- stage 1: rotation products ----------------
   logic signed [CoordW-1:0] pin [0:2];
   logic signed [ProdW-1:0]  s1_prod_in [0:8];
   logic signed [ProdW-1:0]  s1_prod_ff [0:8];
   logic                     s1_valid_ff;

   assign pin[0] = req_data.point_x;
   assign pin[1] = req_data.point_y;
   assign pin[2] = req_data.point_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s1_prod_in[3*i+j] = $signed(rot_ff[i][16*j +: 16]) * pin[j];
         end
      end
   end

   // ---------------- stage 2: sum with translation, round to Q.8 ----------------
   logic signed [AccW-1:0] acc [0:2];
   logic signed [AccW-1:0] rnd [0:2];
   logic signed [CamW-1:0] s2_cam_in [0:2];
   logic signed [CamW-1:0] s2_cam_ff [0:2];
   logic                   s2_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = AccW'($signed(trans_ff[21*i +: 21])) <<< 14;
         for (int j = 0; j < 3; j++) begin
            acc[i] = acc[i] + AccW'(s1_prod_ff[3*i+j]);
         end
         rnd[i]       = acc[i] + AccW'(8192);
         s2_cam_in[i] = rnd[i][AccW-1:14];
      end
   end

   // ---------------- stage 3: focal products, depth check ----------------
   logic signed [FpW-1:0]  s3_fp_in [0:1];
   logic signed [FpW-1:0]  s3_fp_ff [0:1];
   logic signed [CamW-1:0] s3_cam_ff [0:2];
   logic                   s3_bad_in;
   logic                   s3_bad_ff;
   logic                   s3_valid_ff;

   assign s3_fp_in[0] = $signed({1'b0, focal_ff}) * s2_cam_ff[0];
   assign s3_fp_in[1] = $signed({1'b0, focal_ff}) * s2_cam_ff[1];
   assign s3_bad_in   = !tele_ff && (s2_cam_ff[2][CamW-1] || (s2_cam_ff[2] == '0));

   // ---------------- stage 4: divider operands ----------------
   logic [FpW-1:0]  fp_mag [0:1];
   logic [N1W-1:0]  s4_num_in [0:1];
   logic [N1W-1:0]  s4_num_ff [0:1];
   logic [D1W-1:0]  s4_den_in;
   logic [D1W-1:0]  s4_den_ff;
   side1_type       s4_side_in;
   side1_type       s4_side_ff;
   logic            s4_valid_ff;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         fp_mag[i]    = s3_fp_ff[i][FpW-1] ? FpW'(-s3_fp_ff[i]) : FpW'(s3_fp_ff[i]);
         s4_num_in[i] = N1W'({fp_mag[i], 1'b0}) + N1W'(s3_cam_ff[2][CamW-2:0]);
      end
      s4_den_in       = {s3_cam_ff[2][CamW-2:0], 1'b0};
      s4_side_in.bad  = s3_bad_ff;
      s4_side_in.neg  = {s3_fp_ff[1][FpW-1], s3_fp_ff[0][FpW-1]};
      s4_side_in.cam0 = s3_cam_ff[0];
      s4_side_in.cam1 = s3_cam_ff[1];
   end

   // stages 1 to 4 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff   <= s1_prod_in;
         s2_cam_ff    <= s2_cam_in;
         s3_fp_ff     <= s3_fp_in;
         s3_cam_ff    <= s2_cam_ff;
         s3_bad_ff    <= s3_bad_in;
         s4_num_ff    <= s4_num_in;
         s4_den_ff    <= s4_den_in;
         s4_side_ff   <= s4_side_in;
      end
   end

   // ---------------- projection dividers ----------------
   logic [Q1W-1:0] q1 [0:1];
   logic           ovf1 [0:1];
   logic           d1_valid;
   side1_type      d1_side;

   for (genvar g = 0; g < 2; g++) begin : g_div1
      cpp_div_pipe #(.NW(N1W), .DW(D1W), .QW(Q1W)) u_div (
         .clock (clock),
         .en    (en),
         .num_i (s4_num_ff[g]),
         .den_i (s4_den_ff),
         .quo_o (q1[g]),
         .ovf_o (ovf1[g])
      );
   end

   cpp_delay #(.W($bits(side1_type)), .DEPTH(Q1W + 1)) u_delay1 (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (s4_valid_ff),
      .data_i  (s4_side_ff),
      .valid_o (d1_valid),
      .data_o  (d1_side)
   );

   // ---------------- stage 5: sign, clamp to +-2^30 ----------------
   logic signed [63:0] cx [0:1];
   logic [Q1W-1:0]     qmag [0:1];
   logic signed [31:0] uval [0:1];
   logic               clip [0:1];
   car_type            s5_car_in;

   always_comb begin
      cx[0] = 64'($signed(d1_side.cam0));
      cx[1] = 64'($signed(d1_side.cam1));
      for (int i = 0; i < 2; i++) begin
         clip[i] = 1'b0;
         qmag[i] = q1[i];
         if (tele_ff) begin
            if (cx[i] > PreLim) begin
               clip[i] = 1'b1;
               uval[i] = 32'sd1073741824;
            end else if (cx[i] < -PreLim) begin
               clip[i] = 1'b1;
               uval[i] = -32'sd1073741824;
            end else begin
               uval[i] = cx[i][31:0];
            end
         end else begin
            if (ovf1[i] || (q1[i] > Q1W'(32'd1 << 30))) begin
               clip[i] = 1'b1;
               qmag[i] = Q1W'(32'd1 << 30);
            end
            uval[i] = d1_side.neg[i] ? -32'($unsigned(qmag[i])) : 32'($unsigned(qmag[i]));
         end
      end
      s5_car_in.ok  = !d1_side.bad;
      s5_car_in.sat = !d1_side.bad && (clip[0] || clip[1]);
      s5_car_in.u0  = d1_side.bad ? 32'sd0 : uval[0];
      s5_car_in.u1  = d1_side.bad ? 32'sd0 : uval[1];
   end

   // ---------------- stages 5 to 10: radius, kappa term, root argument ----------------
   car_type            s5_car_ff, s6_car_ff, s7_car_ff, s8_car_ff, s9_car_ff, s10_car_ff;
   logic               s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff, s9_valid_ff;
   logic               s10_valid_ff;
   logic signed [63:0] sq_full [0:1];
   logic [61:0]        s6_sq_ff [0:1];
   logic [61:0]        s7_r2_ff;
   logic signed [31:0] kap;
   logic [31:0]        kmag;
   logic [61:0]        s8_phi_ff;
   logic [63:0]        s8_plo_ff;
   logic [62:0]        mraw;
   logic [62:0]        s9_m_in;
   logic [62:0]        s9_m_ff;
   logic [62:0]        argsum;
   logic [62:0]        s10_arg_in;
   logic [62:0]        s10_arg_ff;
   car_type            s10_car_in;

   assign sq_full[0] = s5_car_ff.u0 * s5_car_ff.u0;
   assign sq_full[1] = s5_car_ff.u1 * s5_car_ff.u1;
   assign kap        = $signed(kappa_ff);
   assign kmag       = kap[31] ? 32'(-kap) : kappa_ff;

   // m = |K| * r2 / 2^24 built from the split product, capped at 2^62
   assign mraw    = 63'({s8_phi_ff[53:0], 8'd0}) + 63'(s8_plo_ff[63:24]);
   assign s9_m_in = ((|s8_phi_ff[61:54]) || (mraw > ArgCap)) ? ArgCap : mraw;

   // root argument, negative argument makes the point invalid
   assign argsum = OneQ30 + s9_m_ff;

   always_comb begin
      s10_car_in = s9_car_ff;
      if (!kap[31]) begin
         s10_arg_in = OneQ30 - s9_m_ff;
         if (s9_m_ff > OneQ30) begin
            s10_car_in.ok = 1'b0;
         end
      end else begin
         s10_arg_in = (argsum > ArgCap) ? ArgCap : argsum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff  <= d1_valid;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_car_ff   <= s5_car_in;
         s6_car_ff   <= s5_car_ff;
         s6_sq_ff[0] <= sq_full[0][61:0];
         s6_sq_ff[1] <= sq_full[1][61:0];
         s7_car_ff   <= s6_car_ff;
         s7_r2_ff    <= s6_sq_ff[0] + s6_sq_ff[1];
         s8_car_ff   <= s7_car_ff;
         s8_phi_ff   <= 62'(kmag * s7_r2_ff[61:32]);
         s8_plo_ff   <= 64'(kmag) * 64'(s7_r2_ff[31:0]);
         s9_car_ff   <= s8_car_ff;
         s9_m_ff     <= s9_m_in;
         s10_car_ff  <= s10_car_in;
         s10_arg_ff  <= s10_arg_in;
      end
   end

   // ---------------- square root ----------------
   logic [SqW/2-1:0] sroot;
   logic             d2_valid;
   car_type          d2_car;

   cpp_sqrt_pipe #(.XW(SqW)) u_sqrt (
      .clock  (clock),
      .en     (en),
      .rad_i  ({1'b0, s10_arg_ff}),
      .root_o (sroot)
   );

   cpp_delay #(.W($bits(car_type)), .DEPTH(SqW / 2 + 1)) u_delay2 (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (s10_valid_ff),
      .data_i  (s10_car_ff),
      .valid_o (d2_valid),
      .data_o  (d2_car)
   );

   // ---------------- stage 11: distortion divider operands ----------------
   logic [32:0]      den2;
   logic [31:0]      uabs [0:1];
   logic [N2W-1:0]   s11_num_in [0:1];
   logic [N2W-1:0]   s11_num_ff [0:1];
   logic [D2W-1:0]   s11_den_ff;
   side3_type        s11_side_in;
   side3_type        s11_side_ff;
   logic             s11_valid_ff;

   assign den2 = 33'(32'd1 << 15) + 33'(sroot);

   always_comb begin
      uabs[0] = d2_car.u0[31] ? 32'(-d2_car.u0) : 32'(d2_car.u0);
      uabs[1] = d2_car.u1[31] ? 32'(-d2_car.u1) : 32'(d2_car.u1);
      for (int i = 0; i < 2; i++) begin
         s11_num_in[i] = N2W'({uabs[i][30:0], 17'd0}) + N2W'(den2);
      end
      s11_side_in.ok  = d2_car.ok;
      s11_side_in.sat = d2_car.sat;
      s11_side_in.neg = {d2_car.u1[31], d2_car.u0[31]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_valid_ff <= 1'b0;
      end else if (en) begin
         s11_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s11_num_ff  <= s11_num_in;
         s11_den_ff  <= {den2, 1'b0};
         s11_side_ff <= s11_side_in;
      end
   end

   // ---------------- distortion dividers ----------------
   logic [Q2W-1:0] q2 [0:1];
   logic           ovf2 [0:1];
   logic           d3_valid;
   side3_type      d3_side;

   for (genvar g = 0; g < 2; g++) begin : g_div2
      cpp_div_pipe #(.NW(N2W), .DW(D2W), .QW(Q2W)) u_div (
         .clock (clock),
         .en    (en),
         .num_i (s11_num_ff[g]),
         .den_i (s11_den_ff),
         .quo_o (q2[g]),
         .ovf_o (ovf2[g])
      );
   end

   cpp_delay #(.W($bits(side3_type)), .DEPTH(Q2W + 1)) u_delay3 (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .valid_i (s11_valid_ff),
      .data_i  (s11_side_ff),
      .valid_o (d3_valid),
      .data_o  (d3_side)
   );

   // ---------------- output stage: sign, clamp to pixel range ----------------
   logic [32:0]              q2w [0:1];
   logic signed [CoordW-1:0] pix [0:1];
   logic                     oclip [0:1];
   rsp_type                  rsp_in;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         q2w[i]   = 33'(q2[i]);
         oclip[i] = 1'b0;
         if (d3_side.neg[i]) begin
            if (ovf2[i] || (q2w[i] > OutMag)) begin
               oclip[i] = 1'b1;
               pix[i]   = CoordW'(-OutMag);
            end else begin
               pix[i] = CoordW'(-q2w[i]);
            end
         end else begin
            if (ovf2[i] || (q2w[i] > OutMax)) begin
               oclip[i] = 1'b1;
               pix[i]   = CoordW'(OutMax);
            end else begin
               pix[i] = CoordW'(q2w[i]);
            end
         end
      end
      if (d3_side.ok) begin
         rsp_in.pixel_row = pix[1];
         rsp_in.pixel_col = pix[0];
         rsp_in.valid_res = 1'b1;
         rsp_in.saturated = d3_side.sat || oclip[0] || oclip[1];
      end else begin
         rsp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

FILE: hw/rtl/cpp_delay.sv
// Enabled delay line carrying a valid bit and side data.
// No dependencies.
module cpp_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         valid_i,
   input  logic [W-1:0] data_i,
   output logic         valid_o,
   output logic [W-1:0] data_o
);

   logic         valid_ff [0:DEPTH-1];
   logic [W-1:0] data_ff  [0:DEPTH-1];

   // first tap
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= data_i;
      end
   end

   // remaining taps
   for (genvar k = 1; k < DEPTH; k++) begin : g_tap
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            data_ff[k] <= data_ff[k-1];
         end
      end
   end

   assign valid_o = valid_ff[DEPTH-1];
   assign data_o  = data_ff[DEPTH-1];

endmodule

FILE: hw/rtl/cpp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// No dependencies.
module cpp_div_pipe #(
   parameter int NW = 48,
   parameter int DW = 34,
   parameter int QW = 32
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num_i,
   input  logic [DW-1:0] den_i,
   output logic [QW-1:0] quo_o,
   output logic          ovf_o
);

   localparam int TopW = NW - QW;
   localparam int TW   = (TopW > DW) ? TopW : DW;

   logic [TW-1:0] top_w;
   logic [TW-1:0] den_w;

   logic [DW-1:0] rem_ff [0:QW];
   logic [QW-1:0] low_ff [0:QW];
   logic [QW-1:0] quo_ff [0:QW];
   logic [DW-1:0] den_ff [0:QW];
   logic          ovf_ff [0:QW];

   // quotient fits in QW bits only if the top numerator bits are below the divisor
   assign top_w = TW'(num_i[NW-1:QW]);
   assign den_w = TW'(den_i);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= top_w[DW-1:0];
         low_ff[0] <= num_i[QW-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= den_i;
         ovf_ff[0] <= (top_w >= den_w);
      end
   end

   // one shift-compare-subtract per stage
   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        ge;

      assign trial = {rem_ff[k], low_ff[k][QW-1]};
      assign ge    = (trial >= {1'b0, den_ff[k]});
      assign diff  = trial - {1'b0, den_ff[k]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_ff[k+1] <= {low_ff[k][QW-2:0], 1'b0};
            quo_ff[k+1] <= {quo_ff[k][QW-2:0], ge};
            den_ff[k+1] <= den_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   assign quo_o = quo_ff[QW];
   assign ovf_o = ovf_ff[QW];

endmodule

FILE: hw/rtl/cpp_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage (floor result).
// No dependencies.
module cpp_sqrt_pipe #(
   parameter int XW = 64
) (
   input  logic              clock,
   input  logic              en,
   input  logic [XW-1:0]     rad_i,
   output logic [XW/2-1:0]   root_o
);

   localparam int RW = XW / 2;
   localparam int TW = RW + 4;

   logic [RW+1:0] rem_ff  [0:RW];
   logic [RW-1:0] root_ff [0:RW];
   logic [XW-1:0] rad_ff  [0:RW];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         rad_ff[0]  <= rad_i;
      end
   end

   // bring down two radicand bits, try root*4+1
   for (genvar k = 0; k < RW; k++) begin : g_step
      logic [TW-1:0] rem_t;
      logic [TW-1:0] trial;
      logic [TW-1:0] diff;
      logic          ge;

      assign rem_t = {rem_ff[k], rad_ff[k][XW-1:XW-2]};
      assign trial = TW'({root_ff[k], 2'b01});
      assign ge    = (rem_t >= trial);
      assign diff  = rem_t - trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge ? diff[RW+1:0] : rem_t[RW+1:0];
            root_ff[k+1] <= {root_ff[k][RW-2:0], ge};
            rad_ff[k+1]  <= {rad_ff[k][XW-3:0], 2'b00};
         end
      end
   end

   assign root_o = root_ff[RW];

endmodule

FILE: tb/tb.sv
// Self-checking bench for camera_point_projection: streams 3D points and checks each pixel.
// Depends on cpp_pkg and the camera_point_projection RTL.
// A built-in projector computes the expected pixel for each request at the moment it is accepted.
module tb
   import cpp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PipeDepth  = 120;
   localparam int IdleLimit  = 20000;
   localparam int ShownFails = 10;

   // Index past the last register; writes to it are dropped
   localparam logic [CsrIdxW-1:0] REG_UNUSED = 3'd7;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   camera_point_projection dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Shadow copy of the block's registers
   logic [RotW-1:0]   rot_sh[3];
   logic [TransW-1:0] trans_sh;
   logic [FocalW-1:0] focal_sh;
   logic [KappaW-1:0] kappa_sh;
   logic              tele_sh;

   rsp_type pixel_q[$];
   int      fail_cnt = 0;
   int      idle_cycles = 0;
   int      burst_left = 0;

   // Round n/d to nearest, ties away from zero; d > 0
   function automatic longint div_round(longint n, longint d);
      longint unsigned mag;
      longint unsigned q;
      mag = (n < 0) ? longint'(-n) : n;
      q   = (2 * mag + d) / (2 * d);
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x   -= res + b;
            res  = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // Expected pixel for one world point under the current registers
   function automatic rsp_type project_point(req_type pt);
      longint          p[3];
      longint          c[3];
      longint          acc, u, v, k, pu, pv, omax;
      longint unsigned r2, kmag, phi, plo, m, arg, den;
      bit              sat, ok;
      rsp_type         r;
      p[0] = longint'(pt.point_x);
      p[1] = longint'(pt.point_y);
      p[2] = longint'(pt.point_z);
      for (int i = 0; i < 3; i++) begin
         acc = longint'($signed(trans_sh[21*i +: 21])) * 16384;
         for (int j = 0; j < 3; j++)
            acc += longint'($signed(rot_sh[i][16*j +: 16])) * p[j];
         c[i] = (acc + 8192) >>> 14;
      end
      sat = 1'b0;
      ok  = 1'b1;
      u   = 0;
      v   = 0;
      pu  = 0;
      pv  = 0;
      omax = (64'sd1 <<< (CoordW - 1)) - 1;
      if (tele_sh) begin
         u = c[0];
         v = c[1];
      end else if (c[2] <= 0) begin
         ok = 1'b0;
      end else begin
         u = div_round(longint'(focal_sh) * c[0], c[2]);
         v = div_round(longint'(focal_sh) * c[1], c[2]);
      end
      if (ok) begin
         // clamp ahead of the radius computation
         if (u > (64'sd1 <<< 30)) begin u = 64'sd1 <<< 30; sat = 1'b1; end
         if (u < -(64'sd1 <<< 30)) begin u = -(64'sd1 <<< 30); sat = 1'b1; end
         if (v > (64'sd1 <<< 30)) begin v = 64'sd1 <<< 30; sat = 1'b1; end
         if (v < -(64'sd1 <<< 30)) begin v = -(64'sd1 <<< 30); sat = 1'b1; end
         r2   = u * u + v * v;
         k    = longint'($signed(kappa_sh));
         kmag = (k < 0) ? -k : k;
         phi  = kmag * (r2 >> 32);
         plo  = kmag * (r2 & 64'hFFFF_FFFF);
         if (phi >= (64'd1 << 54)) m = 64'd1 << 62;
         else begin
            m = (phi << 8) + (plo >> 24);
            if (m > (64'd1 << 62)) m = 64'd1 << 62;
         end
         if (k >= 0) begin
            if (m > (64'd1 << 30)) ok = 1'b0;
            arg = (64'd1 << 30) - m;
         end else begin
            arg = (64'd1 << 30) + m;
            if (arg > (64'd1 << 62)) arg = 64'd1 << 62;
         end
         if (ok) begin
            den = (64'd1 << 15) + floor_sqrt(arg);
            pu  = div_round(u * 65536, den);
            pv  = div_round(v * 65536, den);
            if (pu > omax) begin pu = omax; sat = 1'b1; end
            if (pu < -omax - 1) begin pu = -omax - 1; sat = 1'b1; end
            if (pv > omax) begin pv = omax; sat = 1'b1; end
            if (pv < -omax - 1) begin pv = -omax - 1; sat = 1'b1; end
         end
      end
      if (!ok) begin
         pu  = 0;
         pv  = 0;
         sat = 1'b0;
      end
      r.pixel_row = pv[CoordW-1:0];
      r.pixel_col = pu[CoordW-1:0];
      r.valid_res = ok;
      r.saturated = sat;
      return r;
   endfunction

   // Send one request in bursts with random gaps; predict on acceptance
   task automatic send_point(req_type pt);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0 && req_valid) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) :
                                                    $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= pt;
      forever begin
         @(posedge clock);
         if (req_valid && !req_stall) break;
      end
      pixel_q = {pixel_q, project_point(pt)};
   endtask

   // Stop sending and wait until every pixel has come back
   task automatic drain_pipe();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      burst_left = 0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (PipeDepth) @(posedge clock);
   endtask

   // One register write; shadow copy follows, out-of-range index ignored
   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_ROT_ROW0:    rot_sh[0] = val[RotW-1:0];
         REG_ROT_ROW1:    rot_sh[1] = val[RotW-1:0];
         REG_ROT_ROW2:    rot_sh[2] = val[RotW-1:0];
         REG_TRANSLATION: trans_sh  = val[TransW-1:0];
         REG_FOCAL:       focal_sh  = val[FocalW-1:0];
         REG_KAPPA:       kappa_sh  = val[KappaW-1:0];
         REG_TELECENTRIC: tele_sh   = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic req_type make_point(int x, int y, int z);
      req_type pt;
      pt.point_x = CoordW'(x);
      pt.point_y = CoordW'(y);
      pt.point_z = CoordW'(z);
      return pt;
   endfunction

   // Mostly points in front of the camera at sane range, some raw noise
   function automatic req_type rand_point();
      req_type pt;
      if ($urandom_range(0, 4) == 0) begin
         pt.point_x = CoordW'($urandom);
         pt.point_y = CoordW'($urandom);
         pt.point_z = CoordW'($urandom);
      end else begin
         pt.point_x = CoordW'($signed($urandom) >>> $urandom_range(8, 20));
         pt.point_y = CoordW'($signed($urandom) >>> $urandom_range(8, 20));
         pt.point_z = CoordW'($urandom_range(1, 1 << $urandom_range(9, 22)));
      end
      return pt;
   endfunction

   function automatic logic [RotW-1:0] rand_rot(int row);
      logic [RotW-1:0] r;
      if ($urandom_range(0, 2) == 0) begin
         r = RotW'({$urandom, $urandom});
      end else begin
         r = '0;
         for (int j = 0; j < 3; j++)
            r[16*j +: 16] = (j == row) ? 16'(16'h4000 - $urandom_range(0, 2048)) :
                                         16'($signed($urandom) >>> $urandom_range(3, 15));
      end
      return r;
   endfunction

   task automatic rand_config();
      logic [TransW-1:0] tr;
      for (int i = 0; i < 3; i++)
         write_reg(REG_ROT_ROW0 + i[CsrIdxW-1:0], CsrDataW'(rand_rot(i)));
      tr = '0;
      for (int i = 0; i < 3; i++)
         tr[21*i +: 21] = 21'($signed($urandom) >>> $urandom_range(11, 24));
      write_reg(REG_TRANSLATION, tr);
      write_reg(REG_FOCAL, CsrDataW'($urandom_range(1, 1 << $urandom_range(4, 20)) - 1));
      write_reg(REG_KAPPA, CsrDataW'(($urandom_range(0, 3) == 0) ? 0 :
                                     $signed($urandom) >>> $urandom_range(0, 31)));
      write_reg(REG_TELECENTRIC, CsrDataW'($urandom_range(0, 3) == 0));
   endtask

   // Directed points: zero/negative depth, field extremes, reset registers
   task automatic test_reset_geometry();
      send_point(make_point(0, 0, 0));
      send_point(make_point(256, 256, -256));
      send_point(make_point(256, -512, 256));
      send_point(make_point(8388607, 8388607, 8388607));
      send_point(make_point(-8388608, -8388608, 1));
      send_point(make_point(8388607, -8388608, 1));
      send_point(make_point(-8388608, 0, -8388608));
      send_point(make_point(1000, 2000, 25600));
      drain_pipe();
   endtask

   // Register extremes: negative root, huge negative kappa, telecentric, ignored index
   task automatic test_register_extremes();
      write_reg(REG_KAPPA, CsrDataW'(32'h7FFF_FFFF));
      send_point(make_point(25600, 25600, 256));
      send_point(make_point(0, 0, 256));
      drain_pipe();
      write_reg(REG_KAPPA, CsrDataW'(32'h8000_0000));
      write_reg(REG_FOCAL, CsrDataW'(20'hFFFFF));
      send_point(make_point(8388607, -8388608, 1));
      send_point(make_point(300, 300, 256));
      drain_pipe();
      write_reg(REG_TELECENTRIC, CsrDataW'(1'b1));
      write_reg(REG_KAPPA, 63'h7FFF_FFFF_0000_0400);
      write_reg(REG_UNUSED, '1);
      send_point(make_point(8388607, 8388607, -8388608));
      send_point(make_point(-256, 512, 0));
      drain_pipe();
      write_reg(REG_ROT_ROW0, CsrDataW'(48'h8000_8000_8000));
      write_reg(REG_ROT_ROW1, CsrDataW'(48'h7FFF_7FFF_7FFF));
      write_reg(REG_ROT_ROW2, CsrDataW'(48'h8000_7FFF_8000));
      write_reg(REG_TRANSLATION, {21'h0FFFFF, 21'h100000, 21'h0FFFFF});
      write_reg(REG_FOCAL, '0);
      send_point(make_point(8388607, 8388607, 8388607));
      send_point(make_point(-8388608, -8388608, -8388608));
      drain_pipe();
      write_reg(REG_TELECENTRIC, CsrDataW'(1'b0));
      write_reg(REG_TRANSLATION, {21'h100000, 21'h0FFFFF, 21'h100000});
      send_point(make_point(-8388608, 8388607, -8388608));
      send_point(make_point(100, 100, 100));
      drain_pipe();
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 8; ph++) begin
         rand_config();
         repeat (232) send_point(rand_point());
         drain_pipe();
      end
   endtask

   // Result check and receiver stall pattern
   int   stall_mode = 0;
   int   mode_left = 0;
   int   cyc = 0;
   rsp_type want;
   always @(posedge clock) begin
      cyc++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= ShownFails) $display("unexpected pixel %p", rsp_data);
         end else begin
            want = pixel_q.pop_front();
            if (rsp_data !== want) begin
               fail_cnt++;
               if (fail_cnt <= ShownFails)
                  $display("pixel mismatch: want %p got %p", want, rsp_data);
            end
         end
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(64, 512);
      end
      mode_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 7) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (cyc % 5) < 2;
      endcase
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      rot_sh[0] = RotRow0Rst;
      rot_sh[1] = RotRow1Rst;
      rot_sh[2] = RotRow2Rst;
      trans_sh  = '0;
      focal_sh  = FocalRst;
      kappa_sh  = '0;
      tele_sh   = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_register_extremes();
      test_random_phases();
      drain_pipe();
      if (fail_cnt == 0 && pixel_q.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
